/* hdl/sspf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspf_pkg
// Shared types and constants of the servo status frame parser.
// ----------------------------------------------------------------------------
package sspf_pkg;

  localparam int NUM_SERVOS = 4;
  localparam int IDX_W      = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int BYTE_W     = 8;
  localparam int VAL_W      = 16;
  localparam int BIDX_W     = 9;

  localparam logic [BYTE_W-1:0] MIN_LEN = 8'd6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_BAD_ID   = 2'd2,
    ST_SHORT    = 2'd3
  } status_e;

  // One servo table entry: current and previous readings.
  typedef struct packed {
    logic [VAL_W-1:0] cur_pos;
    logic [VAL_W-1:0] cur_spd;
    logic [VAL_W-1:0] prev_pos;
    logic [VAL_W-1:0] prev_spd;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] servo_index;
    logic [VAL_W-1:0] new_position;
    logic [VAL_W-1:0] new_speed;
    logic [VAL_W-1:0] old_position;
    logic [VAL_W-1:0] old_speed;
  } result_t;

endpackage

/* hdl/sspf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspf_if
// Valid/ready channels for received bytes and for per-frame results.
// ----------------------------------------------------------------------------
interface sspf_in_if import sspf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sspf_out_if import sspf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [IDX_W-1:0] servo_index;
  logic [VAL_W-1:0] new_position;
  logic [VAL_W-1:0] new_speed;
  logic [VAL_W-1:0] old_position;
  logic [VAL_W-1:0] old_speed;

  modport source (output valid, output status, output servo_index, output new_position,
                  output new_speed, output old_position, output old_speed, input ready);
  modport sink   (input valid, input status, input servo_index, input new_position,
                  input new_speed, input old_position, input old_speed, output ready);
endinterface

/* hdl/sspf_tbl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspf_tbl
// Servo table memory with one registered read port and one write port.
// ----------------------------------------------------------------------------
module sspf_tbl import sspf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_entry_o,
  input  tbl_wr_t          wr_i
);

  entry_t                mem_q [NUM_SERVOS];
  entry_t                rd_q;
  logic [NUM_SERVOS-1:0] valid_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_q : '0;

endmodule

/* hdl/servo_status_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_frame_parser
// Parses servo status frames byte by byte and keeps a per-servo table.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one received byte per item, with frame_start set on the
//   first byte of a frame. out_o carries one result item per closed frame: a status
//   and the addressed servo's table entry after the update.
//   One byte is accepted every cycle while ready is high. A frame's result is
//   registered when its last byte (checksum byte, or the length byte of a short
//   frame) is accepted. The servo table sits in a small memory; the entry is read
//   as soon as the id byte arrives, so its data is ready long before the checksum
//   byte, and written back when a good frame closes.
//   The output register is backed by a skid register, so bytes keep flowing
//   while a result waits; ready drops only once both hold a result that the
//   receiver has not taken.
//   Reset closes any open frame, empties both result registers and marks all
//   table entries as zero through per-entry valid bits; no clearing pass is
//   needed and the block accepts bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
module servo_status_frame_parser import sspf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  sspf_in_if.sink  in_i,
  sspf_out_if.source out_o
);

  logic [BIDX_W-1:0] idx_q, idx_d, idx_w;
  logic [BYTE_W-1:0] len_q, len_d, len_w;
  logic [BYTE_W-1:0] sum_q, sum_d, sum_w;
  logic [BYTE_W-1:0] id_q, id_d, id_w;
  logic [VAL_W-1:0]  pos_q, pos_d, pos_w;
  logic [VAL_W-1:0]  spd_q, spd_d, spd_w;
  logic              fin_q, fin_d;

  logic              out_vld_q, out_vld_d;
  logic              skid_vld_q, skid_vld_d;
  result_t           out_res_q, out_res_d;
  result_t           skid_res_q, skid_res_d;

  logic              in_fire, pop, push, open_w, id_ok;
  logic [BYTE_W-1:0] b;
  logic [IDX_W-1:0]  cur_idx, rd_addr;
  logic [BYTE_W-1:0] id_m1, id_d_m1;
  entry_t            rd_entry;
  tbl_wr_t           wr;
  status_e           res_st;
  result_t           res;

  assign in_i.ready = ~skid_vld_q;
  assign in_fire    = in_i.valid & in_i.ready;
  assign pop        = out_vld_q & out_o.ready;
  assign b          = in_i.data_byte;

  // A start byte discards whatever frame was open.
  assign open_w = in_i.frame_start | ~fin_q;
  assign idx_w  = in_i.frame_start ? '0 : idx_q;
  assign len_w  = in_i.frame_start ? '0 : len_q;
  assign sum_w  = in_i.frame_start ? '0 : sum_q;
  assign id_w   = in_i.frame_start ? '0 : id_q;
  assign pos_w  = in_i.frame_start ? '0 : pos_q;
  assign spd_w  = in_i.frame_start ? '0 : spd_q;

  assign id_ok   = (id_q != '0) && (id_q <= BYTE_W'(NUM_SERVOS));
  assign id_m1   = id_q - 8'd1;
  assign cur_idx = id_m1[IDX_W-1:0];
  assign id_d_m1 = id_d - 8'd1;
  // Address follows the id being captured, so the registered read lands in the next cycle.
  assign rd_addr = id_d_m1[IDX_W-1:0];

  sspf_tbl u_tbl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_i       (wr)
  );

  always_comb begin
    idx_d  = idx_q;
    len_d  = len_q;
    sum_d  = sum_q;
    id_d   = id_q;
    pos_d  = pos_q;
    spd_d  = spd_q;
    fin_d  = fin_q;
    push   = 1'b0;
    res_st = ST_OK;
    wr     = '0;
    if (in_fire) begin
      idx_d = idx_w;
      len_d = len_w;
      sum_d = sum_w;
      id_d  = id_w;
      pos_d = pos_w;
      spd_d = spd_w;
      fin_d = fin_q & ~in_i.frame_start;
      if (open_w) begin
        if (idx_w == 9'd2) begin
          id_d = b;
        end
        if (idx_w == 9'd3 && b < MIN_LEN) begin
          fin_d  = 1'b1;
          len_d  = b;
          push   = 1'b1;
          res_st = ST_SHORT;
        end else if (idx_w >= 9'd4 && idx_w == ({1'b0, len_w} + 9'd3)) begin
          fin_d = 1'b1;
          push  = 1'b1;
          if (b != ~sum_w) begin
            res_st = ST_CHECKSUM;
          end else if (!id_ok) begin
            res_st = ST_BAD_ID;
          end else begin
            res_st  = ST_OK;
            wr.en   = 1'b1;
            wr.addr = cur_idx;
            wr.data = '{cur_pos: pos_q, cur_spd: spd_q,
                        prev_pos: rd_entry.cur_pos, prev_spd: rd_entry.cur_spd};
          end
        end else begin
          if (idx_w == 9'd3) begin
            len_d = b;
          end
          if (idx_w >= 9'd2) begin
            sum_d = sum_w + b;
          end
          case (idx_w)
            9'd5:    pos_d = {pos_w[15:8], b};
            9'd6:    pos_d = {b, pos_w[7:0]};
            9'd7:    spd_d = {spd_w[15:8], b};
            9'd8:    spd_d = {b, spd_w[7:0]};
            default: ;
          endcase
          idx_d = idx_w + 9'd1;
        end
      end
    end
  end

  // Result fields: the entry as it stands after this frame, or all zero for an id out of range.
  always_comb begin
    res.status       = res_st;
    res.servo_index  = '0;
    res.new_position = '0;
    res.new_speed    = '0;
    res.old_position = '0;
    res.old_speed    = '0;
    if (id_ok) begin
      res.servo_index = cur_idx;
      if (res_st == ST_OK) begin
        res.new_position = pos_q;
        res.new_speed    = spd_q;
        res.old_position = rd_entry.cur_pos;
        res.old_speed    = rd_entry.cur_spd;
      end else begin
        res.new_position = rd_entry.cur_pos;
        res.new_speed    = rd_entry.cur_spd;
        res.old_position = rd_entry.prev_pos;
        res.old_speed    = rd_entry.prev_spd;
      end
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_res_d  = out_res_q;
    skid_res_d = skid_res_q;
    if (push) begin
      if (!out_vld_q || pop) begin
        out_res_d = res;
        out_vld_d = 1'b1;
      end else begin
        skid_res_d = res;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      if (skid_vld_q) begin
        out_res_d  = skid_res_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      id_q       <= '0;
      pos_q      <= '0;
      spd_q      <= '0;
      fin_q      <= 1'b1;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      id_q       <= id_d;
      pos_q      <= pos_d;
      spd_q      <= spd_d;
      fin_q      <= fin_d;
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_res_q.status;
  assign out_o.servo_index  = out_res_q.servo_index;
  assign out_o.new_position = out_res_q.new_position;
  assign out_o.new_speed    = out_res_q.new_speed;
  assign out_o.old_position = out_res_q.old_position;
  assign out_o.old_speed    = out_res_q.old_speed;

endmodule

/* hdl/sspf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspf_checker
// Port-level checks on the servo status frame parser.
// ----------------------------------------------------------------------------
module sspf_checker import sspf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [1:0]       out_status_i,
  input logic [IDX_W-1:0] out_servo_index_i,
  input logic [VAL_W-1:0] out_new_position_i,
  input logic [VAL_W-1:0] out_new_speed_i,
  input logic [VAL_W-1:0] out_old_position_i,
  input logic [VAL_W-1:0] out_old_speed_i
);

  // A rejected id reports no table data at all.
  a_bad_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_BAD_ID |->
      out_servo_index_i == '0 && out_new_position_i == '0 && out_new_speed_i == '0 &&
      out_old_position_i == '0 && out_old_speed_i == '0)
    else $error("bad id result carries table data");

  // A result only appears after a byte was taken.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result appeared without an accepted item");

  // Input backpressure only while a result is pending.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_servo_index_i) && $stable(out_new_position_i) &&
      $stable(out_new_speed_i) && $stable(out_old_position_i) && $stable(out_old_speed_i))
    else $error("stalled result changed");

endmodule

bind servo_status_frame_parser sspf_checker u_sspf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.status),
  .out_servo_index_i  (out_o.servo_index),
  .out_new_position_i (out_o.new_position),
  .out_new_speed_i    (out_o.new_speed),
  .out_old_position_i (out_o.old_position),
  .out_old_speed_i    (out_o.old_speed)
);
